### hdl/btk_pkg.sv
// Package for the bounded sorted top-k list unit: sizes, entry layout,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package btk_pkg;

    // Store geometry
    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);

    // Field widths
    localparam int ID_W  = 16;
    localparam int KEY_W = 32;
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    // Operation codes on the func field
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // One stored entry
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP,
        ST_EVICT,
        ST_UP,
        ST_DN,
        ST_READ,
        ST_PUT,
        ST_DONE
    } t_state;

    // Read address select for the store
    typedef enum logic [2:0] {
        RS_ZERO,
        RS_ONE,
        RS_IDX,
        RS_UP1,
        RS_UP2,
        RS_DN2
    } t_rsel;

    // Commands from controller to datapath
    typedef struct packed {
        logic  load;      // capture input beat
        t_rsel rsel;      // store read address this cycle
        logic  shift_up;  // entry[ptr] <= entry[ptr-1] (read data), ptr--
        logic  shift_dn;  // entry[ptr] <= entry[ptr+1] (read data), ptr++
        logic  put;       // entry[ptr] <= new entry
        logic  cap_ev;    // latch evicted handle from read data
        logic  cap_rd;    // latch read result from read data
        logic  set_err;   // flag bad read index
        logic  emit;      // load output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_read;    // captured beat is a read
        logic idx_ok;     // captured index below count
        logic full;       // count at or above effective capacity
        logic cnt_zero;
        logic cnt_one;
        logic key_lt;     // read key below new key
        logic ptr_is_one;
        logic dn_last;    // ptr + 2 == count
        logic out_free;   // output register can take a result
    } t_dp_status;

endpackage

### hdl/btk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/btk_ctrl.sv
// Controller FSM for the top-k list: sequences the insert walks and reads.
// Depends on btk_pkg.
module btk_ctrl import btk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_st,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rsel = RS_ZERO;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_st.is_read) begin
                    if (i_st.idx_ok) begin
                        o_cmd.rsel = RS_IDX;
                        n_state = ST_READ;
                    end else begin
                        o_cmd.set_err = 1'b1;
                        n_state = ST_DONE;
                    end
                end else if (i_st.full) begin
                    o_cmd.rsel = RS_ZERO;
                    n_state = ST_EVICT;
                end else if (i_st.cnt_zero) begin
                    n_state = ST_PUT;
                end else begin
                    o_cmd.rsel = RS_UP1;
                    n_state = ST_UP;
                end
            end
            ST_EVICT: begin
                // read data holds entry 0
                o_cmd.cap_ev = 1'b1;
                if (i_st.cnt_one) begin
                    n_state = ST_PUT;
                end else begin
                    o_cmd.rsel = RS_ONE;
                    n_state = ST_DN;
                end
            end
            ST_UP: begin
                // read data holds entry ptr-1
                if (!i_st.key_lt) begin
                    o_cmd.shift_up = 1'b1;
                    if (i_st.ptr_is_one) begin
                        n_state = ST_PUT;
                    end else begin
                        o_cmd.rsel = RS_UP2;
                    end
                end else begin
                    o_cmd.put = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DN: begin
                // read data holds entry ptr+1
                if (i_st.key_lt) begin
                    o_cmd.shift_dn = 1'b1;
                    if (i_st.dn_last) begin
                        n_state = ST_PUT;
                    end else begin
                        o_cmd.rsel = RS_DN2;
                    end
                end else begin
                    o_cmd.put = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                o_cmd.cap_rd = 1'b1;
                n_state = ST_DONE;
            end
            ST_PUT: begin
                o_cmd.put = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/btk_dp.sv
// Datapath for the top-k list: entry store, walk pointer, count, minimum,
// capacity register and output register. Depends on btk_pkg and btk_ram.
module btk_dp import btk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_st,
    // input beat
    input  logic              i_func,
    input  logic [ID_W-1:0]   i_item_id,
    input  logic [KEY_W-1:0]  i_fitness,
    input  logic [IDX_W-1:0]  i_index,
    // configuration
    input  logic              i_cfg_valid,
    input  logic [CNT_W-1:0]  i_cfg_data,
    // result beat
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_evicted_valid,
    output logic [ID_W-1:0]   o_evicted_id,
    output logic [ID_W-1:0]   o_read_id,
    output logic [KEY_W-1:0]  o_read_fitness,
    output logic              o_index_error,
    output logic [KEY_W-1:0]  o_lowest_key,
    output logic [CNT_W-1:0]  o_fill_count
);

    // Captured item
    logic               r_func;
    logic [ID_W-1:0]    r_id;
    logic [KEY_W-1:0]   r_key;
    logic [IDX_W-1:0]   r_idx;

    // List state
    logic [ADDR_W-1:0]  r_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [KEY_W-1:0]   r_min;
    logic [CNT_W-1:0]   r_cap;
    logic [CNT_W-1:0]   eff_cap;
    logic               full;

    // Pending result
    logic               r_ev_valid;
    logic [ID_W-1:0]    r_ev_id;
    logic [ID_W-1:0]    r_rd_id;
    logic [KEY_W-1:0]   r_rd_key;
    logic               r_err;

    // Output register
    logic               r_out_valid;
    logic               r_o_ev_valid;
    logic [ID_W-1:0]    r_o_ev_id;
    logic [ID_W-1:0]    r_o_rd_id;
    logic [KEY_W-1:0]   r_o_rd_key;
    logic               r_o_err;
    logic [KEY_W-1:0]   r_o_min;
    logic [CNT_W-1:0]   r_o_cnt;

    // Store ports
    logic               we;
    logic [ADDR_W-1:0]  raddr;
    t_entry             wdata;
    logic [ENTRY_W-1:0] rdata_raw;
    t_entry             rdata;

    btk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_ptr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    assign rdata = t_entry'(rdata_raw);

    // Capacity clamped to 1..DEPTH
    always_comb begin
        eff_cap = r_cap;
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (r_cap > CNT_W'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end
    end

    assign full = (r_cnt >= eff_cap);

    // Read address select
    always_comb begin
        unique case (i_cmd.rsel)
            RS_ZERO: raddr = '0;
            RS_ONE:  raddr = ADDR_W'(1);
            RS_IDX:  raddr = ADDR_W'(r_idx);
            RS_UP1:  raddr = r_ptr - ADDR_W'(1);
            RS_UP2:  raddr = r_ptr - ADDR_W'(2);
            RS_DN2:  raddr = r_ptr + ADDR_W'(2);
            default: raddr = '0;
        endcase
    end

    // Write port: moved entry or the new one, always at the pointer
    assign we    = i_cmd.shift_up | i_cmd.shift_dn | i_cmd.put;
    assign wdata = i_cmd.put ? t_entry'{id: r_id, key: r_key} : rdata;

    // Status to controller
    always_comb begin
        o_st.is_read    = (r_func == FUNC_READ);
        o_st.idx_ok     = (CNT_W'(r_idx) < r_cnt);
        o_st.full       = full;
        o_st.cnt_zero   = (r_cnt == '0);
        o_st.cnt_one    = (r_cnt == CNT_W'(1));
        o_st.key_lt     = (rdata.key < r_key);
        o_st.ptr_is_one = (r_ptr == ADDR_W'(1));
        o_st.dn_last    = ((CNT_W'(r_ptr) + CNT_W'(2)) == r_cnt);
        o_st.out_free   = !r_out_valid || i_out_ready;
    end

    // Control state: count, minimum, capacity, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_min       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            // count grows only when the new entry lands in a list not full
            if (i_cmd.put && !full) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            // entry 0 mirrors into the minimum register
            if (we && r_ptr == '0) begin
                r_min <= wdata.key;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: captured item, walk pointer, pending result, output fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_id       <= i_item_id;
            r_key      <= i_fitness;
            r_idx      <= i_index;
            r_ptr      <= full ? '0 : r_cnt[ADDR_W-1:0];
            r_ev_valid <= 1'b0;
            r_ev_id    <= '0;
            r_rd_id    <= '0;
            r_rd_key   <= '0;
            r_err      <= 1'b0;
        end
        if (i_cmd.shift_up) begin
            r_ptr <= r_ptr - ADDR_W'(1);
        end
        if (i_cmd.shift_dn) begin
            r_ptr <= r_ptr + ADDR_W'(1);
        end
        if (i_cmd.cap_ev) begin
            r_ev_valid <= 1'b1;
            r_ev_id    <= rdata.id;
        end
        if (i_cmd.cap_rd) begin
            r_rd_id  <= rdata.id;
            r_rd_key <= rdata.key;
        end
        if (i_cmd.set_err) begin
            r_err <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_o_ev_valid <= r_ev_valid;
            r_o_ev_id    <= r_ev_id;
            r_o_rd_id    <= r_rd_id;
            r_o_rd_key   <= r_rd_key;
            r_o_err      <= r_err;
            r_o_min      <= r_min;
            r_o_cnt      <= r_cnt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_id    = r_o_ev_id;
    assign o_read_id       = r_o_rd_id;
    assign o_read_fitness  = r_o_rd_key;
    assign o_index_error   = r_o_err;
    assign o_lowest_key    = r_o_min;
    assign o_fill_count    = r_o_cnt;

endmodule

### hdl/bounded_sorted_top_k_list_unit.sv
// Bounded sorted top-k list. A read beat goes through dispatch, a store read and the done state
// (an index at or past the count goes straight to done); an insert into a list not full shifts
// larger entries up before the new one is put, and an insert into a full list first evicts
// entry 0 and shifts smaller entries down; one store read and write per walk cycle. One item
// at a time: the next beat is taken the cycle after the result is loaded.
// Synchronous active-low reset clears count, minimum, FSM and output valid; capacity goes to 32.
module bounded_sorted_top_k_list_unit import btk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_func,
    input  logic [ID_W-1:0]  i_item_id,
    input  logic [KEY_W-1:0] i_fitness,
    input  logic [IDX_W-1:0] i_index,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_evicted_valid,
    output logic [ID_W-1:0]  o_evicted_id,
    output logic [ID_W-1:0]  o_read_id,
    output logic [KEY_W-1:0] o_read_fitness,
    output logic             o_index_error,
    output logic [KEY_W-1:0] o_lowest_key,
    output logic [CNT_W-1:0] o_fill_count
);

    t_dp_cmd    cmd;
    t_dp_status st;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    btk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    btk_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_func          (i_func),
        .i_item_id       (i_item_id),
        .i_fitness       (i_fitness),
        .i_index         (i_index),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .o_read_id       (o_read_id),
        .o_read_fitness  (o_read_fitness),
        .o_index_error   (o_index_error),
        .o_lowest_key    (o_lowest_key),
        .o_fill_count    (o_fill_count)
    );

endmodule

### hdl/btk_chk.sv
// Port-level checker for the top-k list unit, bound to the top level.
// Depends on btk_pkg and bounded_sorted_top_k_list_unit.
module btk_chk import btk_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_evicted_valid,
    input logic             o_index_error,
    input logic [CNT_W-1:0] o_fill_count
);

    // A result beat stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before acceptance");

    // One item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat accepted while busy");

    // Count never exceeds the store depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fill_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // Eviction and index error belong to different operations
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_evicted_valid && o_index_error))
        else $error("eviction and index error in one beat");

    // An eviction leaves a non-empty list
    a_ev_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted_valid |-> o_fill_count != '0)
        else $error("eviction reported with empty list");

endmodule

bind bounded_sorted_top_k_list_unit btk_chk u_chk (.*);

### sim/bounded_sorted_top_k_list_unit_tb.sv
// Self-checking testbench for bounded_sorted_top_k_list_unit: a shadow copy of the
// sorted list predicts every result beat, and random stalls on both channels exercise it.
// Depends on btk_pkg and the unit itself.
module bounded_sorted_top_k_list_unit_tb;
    import btk_pkg::*;

    localparam int IDLE_LIMIT        = 4000;
    localparam int ITEMS_PER_SETTING = 80;
    localparam int SETTING_COUNT     = 12;

    // One result beat, field for field
    typedef struct packed {
        logic             ev_valid;
        logic [ID_W-1:0]  ev_id;
        logic [ID_W-1:0]  rd_id;
        logic [KEY_W-1:0] rd_key;
        logic             idx_err;
        logic [KEY_W-1:0] low_key;
        logic [CNT_W-1:0] fill;
    } t_list_result;

    // Shadow of the sorted list; queues the result each accepted beat must give
    class top_k_shadow;
        logic [ID_W-1:0]  handles[DEPTH];
        logic [KEY_W-1:0] keys[DEPTH];
        int unsigned      fill;
        logic [KEY_W-1:0] low_key;
        logic [CNT_W-1:0] cap_reg;
        t_list_result     pending_results[$];
        int               errors;
        int               inserts;
        int               evictions;
        int               reads;
        int               bad_reads;
        int               settings;

        function new();
            fill      = 0;
            low_key   = '0;
            cap_reg   = CAP_RESET;
            errors    = 0;
            inserts   = 0;
            evictions = 0;
            reads     = 0;
            bad_reads = 0;
            settings  = 0;
        endfunction

        function void set_capacity(logic [CNT_W-1:0] v);
            cap_reg = v;
            settings++;
        endfunction

        // Note an accepted input beat and queue the result it must produce
        function void apply_item(logic f, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
                                 logic [IDX_W-1:0] idx);
            t_list_result r;
            int unsigned  cap;
            int unsigned  pos;
            int unsigned  slot;
            r   = '0;
            // zero acts as one, anything past the store acts as its depth
            cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
            if (f == FUNC_INSERT) begin
                inserts++;
                pos = 0;
                while (pos < fill && keys[pos] < key) pos++;
                if (fill < cap) begin
                    for (int unsigned i = fill; i > pos; i--) begin
                        handles[i] = handles[i-1];
                        keys[i]    = keys[i-1];
                    end
                    handles[pos] = id;
                    keys[pos]    = key;
                    fill++;
                end else begin
                    // full: drop the minimum, slide lower entries down, new one lands below pos
                    slot       = (pos == 0) ? 0 : pos - 1;
                    r.ev_valid = 1'b1;
                    r.ev_id    = handles[0];
                    evictions++;
                    for (int unsigned i = 0; i < slot; i++) begin
                        handles[i] = handles[i+1];
                        keys[i]    = keys[i+1];
                    end
                    handles[slot] = id;
                    keys[slot]    = key;
                end
                low_key = keys[0];
            end else begin
                reads++;
                if (idx < fill) begin
                    r.rd_id  = handles[idx];
                    r.rd_key = keys[idx];
                end else begin
                    r.idx_err = 1'b1;
                    bad_reads++;
                end
            end
            r.low_key = low_key;
            r.fill    = CNT_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [KEY_W-1:0] want_v,
                                    logic [KEY_W-1:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        // Compare a result beat with the oldest outstanding prediction
        function void check_result(t_list_result got);
            t_list_result want;
            if (pending_results.size() == 0) begin
                $error("result beat with no input outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("evicted_valid", want.ev_valid, got.ev_valid);
            compare_field("evicted_id", want.ev_id, got.ev_id);
            compare_field("read_id", want.rd_id, got.rd_id);
            compare_field("read_fitness", want.rd_key, got.rd_key);
            compare_field("index_error", want.idx_err, got.idx_err);
            compare_field("lowest_key", want.low_key, got.low_key);
            compare_field("fill_count", want.fill, got.fill);
        endfunction
    endclass

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic [CNT_W-1:0] cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic             in_func    = FUNC_INSERT;
    logic [ID_W-1:0]  in_id      = '0;
    logic [KEY_W-1:0] in_fitness = '0;
    logic [IDX_W-1:0] in_index   = '0;
    logic             out_ready  = 1'b0;

    logic             o_cfg_ready;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_evicted_valid;
    logic [ID_W-1:0]  o_evicted_id;
    logic [ID_W-1:0]  o_read_id;
    logic [KEY_W-1:0] o_read_fitness;
    logic             o_index_error;
    logic [KEY_W-1:0] o_lowest_key;
    logic [CNT_W-1:0] o_fill_count;

    top_k_shadow shadow = new();
    bit          burst        = 1'b0;
    int          results_seen = 0;
    int          idle_cycles  = 0;

    bounded_sorted_top_k_list_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (in_func),
        .i_item_id       (in_id),
        .i_fitness       (in_fitness),
        .i_index         (in_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .o_read_id       (o_read_id),
        .o_read_fitness  (o_read_fitness),
        .o_index_error   (o_index_error),
        .o_lowest_key    (o_lowest_key),
        .o_fill_count    (o_fill_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Drop valid and let one edge pass so no stale beat is offered
    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Capacity write, only with the list idle
    task automatic write_capacity(logic [CNT_W-1:0] v);
        release_input();
        wait_drained();
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        shadow.set_capacity(v);
    endtask

    // One input beat after a random gap; valid stays up when the gap is zero
    task automatic send_beat(logic f, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
                             logic [IDX_W-1:0] idx);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        in_func    <= f;
        in_id      <= id;
        in_fitness <= key;
        in_index   <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.apply_item(f, id, key, idx);
    endtask

    // Keys: extremes, a few coarse values for ties, neighbors of stored keys, noise
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0: k = '0;
            1: k = '1;
            2, 3: k = KEY_W'($urandom_range(0, 7)) << 16;
            4, 5: begin
                if (shadow.fill > 0) begin
                    k = shadow.keys[$urandom_range(0, shadow.fill - 1)]
                        + KEY_W'($urandom_range(0, 2)) - 1;
                end else begin
                    k = $urandom;
                end
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic random_beat();
        logic             f;
        logic [IDX_W-1:0] idx;
        f = ($urandom_range(0, 9) < 6) ? FUNC_INSERT : FUNC_READ;
        // mostly valid positions, sometimes anywhere in the index range
        if (shadow.fill > 0 && $urandom_range(0, 3) != 0) begin
            idx = IDX_W'($urandom_range(0, shadow.fill - 1));
        end else begin
            idx = IDX_W'($urandom_range(0, 31));
        end
        send_beat(f, ID_W'($urandom_range(0, 65535)), pick_key(), idx);
    endtask

    // Stimulus
    initial begin
        int               caps[SETTING_COUNT] = '{8, 12, 3, 20, 32, 33, 1, 2, 16, 0, 63, 0};
        logic [CNT_W-1:0] cap_v;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero capacity acts as one: empty read, then a one-entry list that evicts on every later insert
        write_capacity('0);
        send_beat(FUNC_READ, 16'h0000, 32'h0000_0000, 5'd0);
        send_beat(FUNC_INSERT, 16'h0001, 32'h0005_0000, 5'd0);
        send_beat(FUNC_INSERT, 16'h0002, 32'h0003_0000, 5'd0);
        send_beat(FUNC_INSERT, 16'h0003, 32'h0007_0000, 5'd0);
        send_beat(FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
        send_beat(FUNC_INSERT, 16'h0000, 32'h0000_0000, 5'd0);
        send_beat(FUNC_READ, 16'h0000, 32'h0000_0000, 5'd0);
        send_beat(FUNC_READ, 16'hFFFF, 32'hFFFF_FFFF, 5'd1);

        // capacity past the store depth; equal keys and key extremes
        write_capacity('1);
        send_beat(FUNC_INSERT, 16'h1234, 32'h0001_8000, 5'd0);
        send_beat(FUNC_INSERT, 16'h1235, 32'h0001_8000, 5'd0);
        send_beat(FUNC_INSERT, 16'hABCD, 32'hFFFF_FFFF, 5'd0);
        send_beat(FUNC_INSERT, 16'h4321, 32'h0000_0000, 5'd0);
        for (int i = 0; i < 5; i++) send_beat(FUNC_READ, 16'h0000, 32'h0, IDX_W'(i));
        send_beat(FUNC_READ, 16'h0000, 32'h0, 5'd31);
        send_beat(FUNC_READ, 16'h0000, 32'h0, 5'd5);

        // random phases, each under its own capacity; count only grows, so some
        // settings land below the fill level
        for (int s = 0; s < SETTING_COUNT; s++) begin
            cap_v = (s == SETTING_COUNT - 1) ? CNT_W'($urandom_range(0, 63)) : CNT_W'(caps[s]);
            write_capacity(cap_v);
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
                // occasional hold-off until every result is back
                if (n == ITEMS_PER_SETTING / 2 || $urandom_range(0, 59) == 0) begin
                    release_input();
                    wait_drained();
                end
                random_beat();
            end
        end

        release_input();
        wait_drained();
        repeat (DEPTH + 8) @(posedge i_clk);
        $display("covered %0d inserts (%0d evictions) and %0d reads (%0d past the fill count)",
                 shadow.inserts, shadow.evictions, shadow.reads, shadow.bad_reads);
        $display("over %0d capacity writes, %0d result beats checked",
                 shadow.settings, results_seen);
        if (shadow.errors == 0) begin
            $display("bounded_sorted_top_k_list_unit_tb: clean");
        end else begin
            $display("bounded_sorted_top_k_list_unit_tb: errors");
        end
        $finish;
    end

    // Result side: random stall per beat, ready held when the stall is zero
    initial begin
        int           stall;
        t_list_result got;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.ev_valid = o_evicted_valid;
            got.ev_id    = o_evicted_id;
            got.rd_id    = o_read_id;
            got.rd_key   = o_read_fitness;
            got.idx_err  = o_index_error;
            got.low_key  = o_lowest_key;
            got.fill     = o_fill_count;
            results_seen++;
            shadow.check_result(got);
        end
    end

    // Watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((in_valid && o_in_ready) || (out_ready && o_out_valid) ||
                     (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("bounded_sorted_top_k_list_unit_tb: errors");
                $finish;
            end
        end
    end

endmodule
